// ----- sv/ucb_pkg.sv -----
// Package: shared constants and types of the UCB1 child selector.
`timescale 1ns / 1ps
package ucb_pkg;
    localparam int MAX_CHILDREN_DEF = 64;
    localparam int VISIT_BITS_DEF   = 20;
    localparam int WINS_W  = 21;
    localparam int SCORE_W = 24;
    localparam int IDX_W   = 6;
    localparam int CW_W    = 16;
    localparam logic [15:0] LN2_Q16   = 16'd45426;
    localparam logic [15:0] CW_RESET  = 16'd4096;
    localparam logic [23:0] SCORE_MAX = 24'h7FFFFF;

    typedef enum logic [0:0] {
        REG_WEIGHT = 1'b0,
        REG_MAXP   = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_RATE, S_LZ, S_LOG, S_LN, S_RATIO, S_SQRT, S_UMUL, S_SCORE, S_OUT
    } t_state;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_div_ctl;

    localparam logic [1:0] DIV_RATE  = 2'd0;
    localparam logic [1:0] DIV_RATIO = 2'd1;
endpackage

// ----- sv/ucb_div.sv -----
// Shared iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ucb_div import ucb_pkg::*; #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done;
    logic [DEN_W:0]   w_trial;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy;
        w_trial = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        if (i_start) begin
            n_q = i_num; n_rem = '0; n_cnt = CNT_W'(NUM_W); n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_q = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q = {r_q[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_cnt <= n_cnt;
            r_done <= r_busy && (r_cnt == CNT_W'(1)) && !i_start;
        end
        r_q <= n_q; r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

// ----- sv/ucb1_child_select.sv -----
// UCB1 child selector (top level).
//
// Children of one node arrive one item at a time on the i_valid/o_ready
// input channel; the input is ready only while the sequencer is idle. A
// visited child runs through one shared divider and small multipliers:
// win-rate divide, leading-one search, sixteen squaring steps and ln
// scaling when the parent count exceeds one, ratio divide, a bit-pair
// square root, then the c multiply, the compare and the position update.
// A visited child keeps the input busy until it has passed all these
// steps; an unvisited or ignored child goes from the rate step straight
// to the compare and the position update. The last child of a set loads
// one result item into an output register in its position update step.
// The next set proceeds while the result waits; only its last child holds
// in the final step until the receiver takes the earlier result.
// Configuration writes land at once and are meant only while idle.
// Synchronous active-low reset clears the running set and restores
// exploration weight 1.0 and max player 0.
`timescale 1ns / 1ps
module ucb1_child_select import ucb_pkg::*; #(
    parameter int MAX_CHILDREN = MAX_CHILDREN_DEF,
    parameter int VISIT_BITS   = VISIT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [CW_W-1:0]      i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [WINS_W-1:0]    i_child_wins_halves,
    input  logic [VISIT_BITS-1:0] i_child_visits,
    input  logic [VISIT_BITS-1:0] i_parent_visits,
    input  logic                 i_child_player,
    input  logic                 i_parent_is_root,
    input  logic                 i_last_child,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [IDX_W-1:0]     o_chosen_index,
    output logic signed [SCORE_W-1:0] o_chosen_score,
    output logic                 o_chose_unvisited
);
    localparam int POS_W = $clog2(MAX_CHILDREN + 1);
    localparam int NUM_W = WINS_W + 15 > 24 + 16 ? WINS_W + 15 : 24 + 16;
    localparam int LZ_W  = $clog2(VISIT_BITS);

    t_state r_state, n_state;
    logic [CW_W-1:0] r_cw;
    logic            r_maxp;
    logic [POS_W-1:0] r_pos;
    logic signed [SCORE_W-1:0] r_best;
    logic [POS_W-1:0] r_best_pos;
    logic            r_maxing, r_unv, r_have;
    logic [VISIT_BITS-1:0] r_pcnt, r_vis;
    logic [WINS_W-1:0] r_wins;
    logic            r_last;
    logic [23:0]     r_rate;
    logic [LZ_W-1:0] r_k;
    logic [32:0]     r_m;
    logic [63:0]     r_sq;
    logic            r_ph;
    logic [4:0]      r_it;
    logic [15:0]     r_frac;
    logic [39:0]     r_ln;
    logic [39:0]     r_rad;
    logic [21:0]     r_res;
    logic [41:0]     r_rem;
    logic [39:0]     r_u;
    logic            r_ovalid;
    logic [IDX_W-1:0] r_oidx;
    logic signed [SCORE_W-1:0] r_oscore;
    logic            r_ounv;

    t_div_ctl        w_div;
    logic [NUM_W-1:0] w_num, w_quo;
    logic            w_ddone;
    logic            w_acc, w_active, w_ohold;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc = i_valid && o_ready;
    assign w_active = (r_pos < POS_W'(MAX_CHILDREN)) && !r_unv;
    assign w_ohold = r_last && r_ovalid && !i_ready;

    always_comb begin
        w_div.start = 1'b0; w_div.op = DIV_RATE;
        w_num = NUM_W'({r_wins, 15'd0});
        if (r_state == S_RATE && r_ph == 1'b0 && w_active && r_vis != '0)
            w_div.start = 1'b1;
        if (r_state == S_RATIO && r_ph == 1'b0) begin
            w_div.start = 1'b1; w_div.op = DIV_RATIO; w_num = NUM_W'(r_ln);
        end
    end

    ucb_div #(.NUM_W(NUM_W), .DEN_W(VISIT_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div.start), .i_num(w_num),
        .i_den(r_vis), .o_done(w_ddone), .o_quo(w_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_acc) n_state = S_RATE;
            S_RATE:  if (r_ph == 1'b0 && !(w_active && r_vis != '0)) n_state = S_SCORE;
                     else if (w_ddone) n_state = S_LZ;
            S_LZ:    if (r_pcnt <= VISIT_BITS'(1)) n_state = S_RATIO;
                     else if (r_pcnt[r_k]) n_state = S_LOG;
            S_LOG:   if (r_ph && r_it == 5'd15) n_state = S_LN;
            S_LN:    if (r_ph) n_state = S_RATIO;
            S_RATIO: if (w_ddone) n_state = S_SQRT;
            S_SQRT:  if (r_it == 5'd19) n_state = S_UMUL;
            S_UMUL:  n_state = S_SCORE;
            S_SCORE: n_state = S_OUT;
            S_OUT:   if (!w_ohold) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic [41:0] w_trial;
    logic signed [25:0] w_score;
    logic signed [SCORE_W-1:0] w_sat;
    logic w_better;
    always_comb begin
        w_trial = {r_rem[39:0], r_rad[39:38]} - {18'd0, r_res, 2'b01};
        w_score = r_maxing ? $signed({2'b0, r_rate}) + $signed({2'b0, r_u[23:0]})
                           : $signed({2'b0, r_rate}) - $signed({2'b0, r_u[23:0]});
        if (r_maxing && r_u > 40'd8388608) w_score = 26'sd8388607;
        if (!r_maxing && r_u > 40'd8388608)
            w_score = $signed({2'b0, r_rate}) - 26'sd8388608;
        if (w_score > 26'sd8388607) w_sat = SCORE_MAX;
        else if (w_score < -26'sd8388608) w_sat = 24'h800000;
        else w_sat = w_score[SCORE_W-1:0];
        w_better = !r_have || (r_maxing ? w_sat > r_best : w_sat < r_best);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cw <= CW_RESET; r_maxp <= 1'b0;
            r_pos <= '0; r_best <= '0; r_best_pos <= '0; r_maxing <= 1'b0;
            r_unv <= 1'b0; r_have <= 1'b0; r_pcnt <= '0; r_ovalid <= 1'b0;
            r_ph <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (t_reg_idx'(i_cfg_idx) == REG_WEIGHT) r_cw <= i_cfg_data;
                else r_maxp <= i_cfg_data[0];
            end
            if (r_state == S_OUT && r_last && !w_ohold) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_ph <= 1'b0;
                    if (w_acc) begin
                        r_wins <= i_child_wins_halves; r_vis <= i_child_visits;
                        r_last <= i_last_child;
                        if (r_pos == '0) begin
                            r_pcnt <= i_parent_visits;
                            r_maxing <= i_parent_is_root || (i_child_player == r_maxp);
                        end
                    end
                end
                S_RATE: begin
                    r_ph <= !w_ddone;
                    if (r_ph == 1'b0 && w_active && r_vis == '0) begin
                        r_unv <= 1'b1; r_best_pos <= r_pos; r_best <= '0;
                    end
                    if (w_ddone) begin
                        r_rate <= (w_quo > NUM_W'(SCORE_MAX)) ? SCORE_MAX : w_quo[23:0];
                        r_k <= LZ_W'(VISIT_BITS - 1); r_ln <= '0;
                    end
                end
                S_LZ: begin
                    r_ph <= 1'b0;
                    if (r_pcnt[r_k]) begin
                        r_m <= 33'({r_pcnt, 31'd0} >> r_k);
                        r_it <= '0; r_frac <= '0;
                    end else r_k <= r_k - 1'b1;
                end
                S_LOG: begin
                    r_ph <= !r_ph;
                    if (!r_ph) r_sq <= r_m * r_m;
                    else begin
                        r_it <= r_it + 1'b1;
                        if (r_sq[63:31] >= 33'h100000000) begin
                            r_frac <= {r_frac[14:0], 1'b1}; r_m <= {1'b0, r_sq[63:32]};
                        end else begin
                            r_frac <= {r_frac[14:0], 1'b0}; r_m <= r_sq[63:31];
                        end
                    end
                end
                S_LN: begin
                    r_ph <= !r_ph;
                    if (!r_ph) r_sq <= 64'({r_k, r_frac}) * 64'(LN2_Q16);
                    else r_ln <= 40'(r_sq >> 16);
                end
                S_RATIO: begin
                    r_ph <= !w_ddone;
                    if (w_ddone) begin
                        r_rad <= {w_quo[23:0], 16'd0}; r_res <= '0; r_rem <= '0;
                        r_it <= '0;
                    end
                end
                S_SQRT: begin
                    r_ph <= 1'b0;
                    r_it <= r_it + 1'b1;
                    r_rad <= {r_rad[37:0], 2'b00};
                    if (!w_trial[41]) begin
                        r_rem <= w_trial; r_res <= {r_res[20:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[39:0], r_rad[39:38]}; r_res <= {r_res[20:0], 1'b0};
                    end
                end
                S_UMUL: begin
                    r_ph <= 1'b0;
                    r_u <= 40'(({24'd0, r_cw} * {18'd0, r_res}) >> 12);
                end
                S_SCORE: begin
                    r_ph <= 1'b0;
                    if (w_active && r_vis != '0 && w_better) begin
                        r_best <= w_sat; r_best_pos <= r_pos; r_have <= 1'b1;
                    end
                end
                S_OUT: begin
                    r_ph <= 1'b0;
                    if (!w_ohold) begin
                        if (r_last) begin
                            r_oidx <= IDX_W'(r_best_pos);
                            r_oscore <= r_unv ? '0 : r_best;
                            r_ounv <= r_unv;
                            r_pos <= '0; r_best <= '0; r_best_pos <= '0; r_maxing <= 1'b0;
                            r_pcnt <= '0; r_unv <= 1'b0; r_have <= 1'b0;
                        end else if (r_pos < POS_W'(MAX_CHILDREN)) begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                end
                default: r_ph <= 1'b0;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_chosen_index = r_oidx;
    assign o_chosen_score = r_oscore;
    assign o_chose_unvisited = r_ounv;

`ifndef NO_ASSERTIONS
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_unv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_chose_unvisited) |-> o_chosen_score == '0)
        else $error("unvisited score nonzero");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_chosen_index))
        else $error("result dropped");
`endif
endmodule

// ----- tb/tb_top.sv -----
// Testbench for ucb1_child_select: directed and random child sets checked against a UCB1 score predictor.
`timescale 1ns / 1ps
module tb_top;
    import ucb_pkg::*;

    typedef struct {
        logic [WINS_W-1:0] wins;
        logic [19:0]       visits;
        logic [19:0]       pvis;
        logic              player;
        logic              root;
        logic              last;
    } t_child;

    typedef struct {
        logic [IDX_W-1:0]   index;
        logic [SCORE_W-1:0] score;
        logic               unvisited;
    } t_choice;

    class ucb_scoreboard;
        bit [15:0] weight;
        bit        max_player;
        int        position;
        bit signed [31:0] best_score;
        int        best_position;
        bit        maximizing;
        bit [19:0] parent_count;
        bit        found_unvisited;
        bit        have_best;
        t_choice   pending[$];
        int        errors;

        function void clear_set();
            position = 0;
            best_score = 0;
            best_position = 0;
            maximizing = 0;
            parent_count = 0;
            found_unvisited = 0;
            have_best = 0;
        endfunction

        function void reset();
            weight = CW_RESET;
            max_player = 0;
            clear_set();
        endfunction

        function bit [63:0] ln_q16(bit [63:0] n);
            int k;
            bit [63:0] m;
            bit [63:0] frac;
            if (n <= 1) return 0;
            k = 0;
            frac = 0;
            while ((n >> (k + 1)) != 0) k++;
            m = n << (31 - k);
            for (int i = 0; i < 16; i++) begin
                m = (m * m) >> 31;
                frac = frac << 1;
                if (m >= 64'h1_0000_0000) begin
                    frac = frac | 1;
                    m = m >> 1;
                end
            end
            return ((((64'(k)) << 16) | frac) * 64'(LN2_Q16)) >> 16;
        endfunction

        function bit [63:0] int_sqrt(bit [63:0] v);
            bit [63:0] res;
            bit [63:0] bits;
            res = 0;
            bits = 64'd1 << 62;
            while (bits > v) bits = bits >> 2;
            while (bits != 0) begin
                if (v >= res + bits) begin
                    v = v - (res + bits);
                    res = (res >> 1) + bits;
                end else begin
                    res = res >> 1;
                end
                bits = bits >> 2;
            end
            return res;
        endfunction

        function void note_child(t_child c);
            bit [63:0] rate;
            bit [63:0] root;
            bit [63:0] u;
            longint    score;
            bit        better;
            t_choice   r;
            if (position == 0) begin
                parent_count = c.pvis;
                maximizing = c.root || (c.player == max_player);
            end
            if (position < MAX_CHILDREN_DEF && !found_unvisited) begin
                if (c.visits == 0) begin
                    found_unvisited = 1;
                    best_position = position;
                    best_score = 0;
                end else begin
                    rate = (64'(c.wins) << 15) / 64'(c.visits);
                    if (rate > 64'd8388607) rate = 64'd8388607;
                    root = int_sqrt((ln_q16(64'(parent_count)) / 64'(c.visits)) << 16);
                    u = (64'(weight) * root) >> 12;
                    if (u > 64'd8388608) u = 64'd8388608;
                    score = maximizing ? longint'(rate) + longint'(u)
                                       : longint'(rate) - longint'(u);
                    if (score > 8388607) score = 8388607;
                    if (score < -8388608) score = -8388608;
                    better = !have_best ||
                             (maximizing ? score > best_score : score < best_score);
                    if (better) begin
                        best_score = 32'(score);
                        best_position = position;
                        have_best = 1;
                    end
                end
            end
            if (position < MAX_CHILDREN_DEF) position++;
            if (c.last) begin
                r.index = best_position[IDX_W-1:0];
                r.score = found_unvisited ? '0 : best_score[SCORE_W-1:0];
                r.unvisited = found_unvisited;
                pending = {pending, r};
                clear_set();
            end
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(logic [IDX_W-1:0] index, logic [SCORE_W-1:0] score,
                          logic unvisited);
            t_choice e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result, index", int'(index), -1);
                return;
            end
            e = pending.pop_front();
            if (index !== e.index)
                report_mismatch("chosen_index", int'(index), int'(e.index));
            if (score !== e.score)
                report_mismatch("chosen_score", int'($signed(score)), int'($signed(e.score)));
            if (unvisited !== e.unvisited)
                report_mismatch("chose_unvisited", int'(unvisited), int'(e.unvisited));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic                 i_cfg_idx;
    logic [CW_W-1:0]      i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [WINS_W-1:0]    i_child_wins_halves;
    logic [19:0]          i_child_visits;
    logic [19:0]          i_parent_visits;
    logic                 i_child_player;
    logic                 i_parent_is_root;
    logic                 i_last_child;
    logic                 o_valid;
    logic                 i_ready;
    logic [IDX_W-1:0]     o_chosen_index;
    logic signed [SCORE_W-1:0] o_chosen_score;
    logic                 o_chose_unvisited;

    ucb_scoreboard sb;
    bit  tx_steady;
    bit  rx_steady;
    int  rx_stall;
    int  items_sent;

    ucb1_child_select u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_child_wins_halves(i_child_wins_halves), .i_child_visits(i_child_visits),
        .i_parent_visits(i_parent_visits), .i_child_player(i_child_player),
        .i_parent_is_root(i_parent_is_root), .i_last_child(i_last_child),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_chosen_index(o_chosen_index), .o_chosen_score(o_chosen_score),
        .o_chose_unvisited(o_chose_unvisited)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_stall <= 0;
        end else if (o_valid && i_ready) begin
            sb.check_result(o_chosen_index, o_chosen_score, o_chose_unvisited);
            rx_stall <= rx_steady ? 0 : $urandom_range(0, 7);
            i_ready <= 1'b0;
        end else if (rx_stall != 0) begin
            rx_stall <= rx_stall - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic send_child(t_child c);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_child_wins_halves <= c.wins;
        i_child_visits <= c.visits;
        i_parent_visits <= c.pvis;
        i_child_player <= c.player;
        i_parent_is_root <= c.root;
        i_last_child <= c.last;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sb.note_child(c);
        items_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CW_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WEIGHT) sb.weight = data;
        else sb.max_player = data[0];
    endtask

    function automatic t_child make_child(logic [WINS_W-1:0] w, logic [19:0] v,
                                          logic [19:0] p, logic pl, logic rt, logic lst);
        t_child c;
        c.wins = w;
        c.visits = v;
        c.pvis = p;
        c.player = pl;
        c.root = rt;
        c.last = lst;
        return c;
    endfunction

    function automatic t_child rand_child(logic lst);
        t_child c;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0) c.visits = '0;
        else if (mode == 1) c.visits = 20'($urandom);
        else if (mode < 5) c.visits = 20'($urandom_range(1, 4000));
        else c.visits = 20'($urandom_range(1, 64));
        if (mode <= 2) c.wins = 21'($urandom);
        else c.wins = 21'($urandom_range(0, 2 * c.visits));
        c.pvis = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 5000));
        c.player = 1'($urandom);
        c.root = ($urandom_range(0, 3) == 0);
        c.last = lst;
        return c;
    endfunction

    task automatic random_sets(int count);
        int n;
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            n = ($urandom_range(0, 60) == 0) ? $urandom_range(65, 72) : $urandom_range(1, 8);
            for (int i = 0; i < n; i++) send_child(rand_child(i == n - 1));
        end
    endtask

    initial begin
        #40ms;
        $display("ucb1_child_select regression: fail");
        $finish;
    end

    initial begin
        sb = new();
        sb.reset();
        sb.errors = 0;
        items_sent = 0;
        tx_steady = 0;
        rx_steady = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_WEIGHT;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_child_wins_halves <= '0;
        i_child_visits <= '0;
        i_parent_visits <= '0;
        i_child_player <= 1'b0;
        i_parent_is_root <= 1'b0;
        i_last_child <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, ties, unvisited and direction cases at reset settings
        send_child(make_child('1, '1, '1, 1'b0, 1'b0, 1'b1));
        send_child(make_child('1, 20'd1, 20'd1000, 1'b1, 1'b0, 1'b1));
        send_child(make_child(21'd4, 20'd3, 20'd0, 1'b1, 1'b0, 1'b0));
        send_child(make_child(21'd2, 20'd3, 20'd9, 1'b0, 1'b0, 1'b1));
        send_child(make_child(21'd5, 20'd7, 20'd1, 1'b1, 1'b1, 1'b1));
        send_child(make_child(21'd0, 20'd0, 20'd50, 1'b0, 1'b0, 1'b1));
        send_child(make_child(21'd6, 20'd4, 20'd20, 1'b1, 1'b0, 1'b0));
        send_child(make_child(21'd6, 20'd4, 20'd99, 1'b0, 1'b1, 1'b0));
        send_child(make_child(21'd0, 20'd0, 20'd1, 1'b1, 1'b0, 1'b0));
        send_child(make_child(21'd9, 20'd2, 20'd0, 1'b0, 1'b0, 1'b1));
        send_child(make_child(21'd0, 20'd5, 20'hFFFFF, 1'b1, 1'b0, 1'b0));
        send_child(make_child(21'd0, 20'd5, 20'd3, 1'b1, 1'b0, 1'b1));
        drain();
        write_reg(REG_WEIGHT, 16'hFFFF);
        write_reg(REG_MAXP, 16'd1);
        send_child(make_child(21'd0, 20'd1, 20'hFFFFF, 1'b0, 1'b0, 1'b0));
        send_child(make_child(21'd0, 20'd1, 20'd7, 1'b1, 1'b0, 1'b1));
        send_child(make_child(21'd0, 20'd1, 20'hFFFFF, 1'b1, 1'b0, 1'b0));
        send_child(make_child('1, 20'd1, 20'd7, 1'b0, 1'b0, 1'b1));
        random_sets(300);
        drain();

        write_reg(REG_WEIGHT, 16'h0000);
        write_reg(REG_MAXP, 16'd0);
        tx_steady = 1;
        rx_steady = 1;
        random_sets(300);
        drain();

        write_reg(REG_WEIGHT, 16'($urandom));
        write_reg(REG_MAXP, 16'd1);
        tx_steady = 0;
        random_sets(350);
        drain();

        write_reg(REG_WEIGHT, CW_RESET);
        write_reg(REG_MAXP, 16'd0);
        rx_steady = 0;
        random_sets(360);

        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ucb1_child_select regression: pass");
        end else begin
            $display("ucb1_child_select regression: fail");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/ucb_pkg.sv
sv/ucb_div.sv
sv/ucb1_child_select.sv
tb/tb_top.sv
